// ----- rtl/bzh_pkg.sv -----
`default_nettype none
package bzh_pkg;

  localparam int TQ               = 30;
  localparam int CNT_W            = 16;
  localparam int T_W              = TQ + 1;
  localparam int COORD_W          = 32;
  localparam int W_W              = TQ + 1;
  localparam int ACC_W            = 66;
  localparam int MAG_W            = 64;
  localparam int CV_W             = 44;
  localparam int ANG_W            = 32;
  localparam int HEAD_W           = 16;
  localparam int NPTS             = 6;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 3;

  localparam logic [T_W-1:0] TONE = T_W'(1) << TQ;

  localparam logic [CFG_IDX_W-1:0] CFG_CP0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CP1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CP2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CP3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CP4   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CP5   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd6;

  typedef struct packed {
    logic [NPTS-1:0][W_W-1:0] w;
    logic [NPTS-2:0][W_W-1:0] q;
  } weight_set_t;

  function automatic logic [T_W-1:0] mulq(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
    logic [2*T_W-1:0] p;
    p = (2*T_W)'(a) * (2*T_W)'(b) + ((2*T_W)'(1) << (TQ - 1));
    return p[TQ+T_W-1:TQ];
  endfunction

  function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/quintic_bezier_point_heading_unit.sv -----
// Quintic Bezier point and heading unit. Each accepted sample_index gives one
// word: the curve point (signed Q16.16, saturated) at t = index/(count-1),
// clamped to 1, and the heading of the tangent clockwise from north in
// 1/65536 turn (0 for a zero tangent). One index is taken every cycle while
// in_stall is low. The pipeline runs through the restoring t divider (one
// quotient bit per stage), the Bernstein power chain, the weighted sums and
// rounding, magnitude normalization and quadrant fold, the CORDIC steps and
// an output register. The user must write control points and sample_count
// through cfg_* while no word is in flight; the block does not check this.
`default_nettype none
module quintic_bezier_point_heading_unit #(
  parameter int CORDIC_STEPS = bzh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bzh_pkg::CNT_W-1:0]        in_sample_index,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [bzh_pkg::COORD_W-1:0]    out_point_x,
  output logic signed [bzh_pkg::COORD_W-1:0]    out_point_y,
  output logic [bzh_pkg::HEAD_W-1:0]            out_heading,
  input  wire logic                             cfg_we,
  input  wire logic [bzh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bzh_pkg::CFG_W-1:0]        cfg_data
);
  import bzh_pkg::*;

  logic [NPTS-1:0][CFG_W-1:0] cp_r;
  logic [CNT_W-1:0]           count_r;
  logic                       en;

  logic                      div_v, bas_v, acc_v;
  logic [T_W-1:0]            div_t;
  weight_set_t               bas_w;
  logic signed [COORD_W-1:0] acc_px, acc_py;
  logic signed [ACC_W-1:0]   acc_dx, acc_dy;
  logic [2*COORD_W-1:0]      side_o;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r    <= '0;
      count_r <= CNT_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CP0:   cp_r[0] <= cfg_data;
        CFG_CP1:   cp_r[1] <= cfg_data;
        CFG_CP2:   cp_r[2] <= cfg_data;
        CFG_CP3:   cp_r[3] <= cfg_data;
        CFG_CP4:   cp_r[4] <= cfg_data;
        CFG_CP5:   cp_r[5] <= cfg_data;
        CFG_COUNT: count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  bzh_div u_div (
    .clk, .rst_n, .en,
    .vld_in  (in_valid),
    .idx     (in_sample_index),
    .count   (count_r),
    .vld_out (div_v),
    .t_out   (div_t)
  );

  bzh_basis u_basis (
    .clk, .rst_n, .en,
    .vld_in  (div_v),
    .t_in    (div_t),
    .vld_out (bas_v),
    .wts     (bas_w)
  );

  bzh_accum u_accum (
    .clk, .rst_n, .en,
    .vld_in  (bas_v),
    .wts     (bas_w),
    .cp      (cp_r),
    .vld_out (acc_v),
    .px_out  (acc_px),
    .py_out  (acc_py),
    .dx_out  (acc_dx),
    .dy_out  (acc_dy)
  );

  bzh_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .en,
    .vld_in   (acc_v),
    .dx       (acc_dx),
    .dy       (acc_dy),
    .side_in  ({acc_py, acc_px}),
    .vld_out  (out_valid),
    .side_out (side_o),
    .heading  (out_heading)
  );

  assign out_point_x = side_o[COORD_W-1:0];
  assign out_point_y = side_o[2*COORD_W-1:COORD_W];

`ifndef ASSERT_OFF
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_v |-> div_t <= TONE) else $error("t above one");

  a_end_wts: assert property (@(posedge clk) disable iff (!rst_n)
    bas_v |-> (bas_w.w[0] <= TONE) && (bas_w.w[5] <= TONE))
    else $error("end weight above one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_heading))
    else $error("stalled word lost");
`endif

endmodule
`default_nettype wire

// ----- rtl/bzh_div.sv -----
`default_nettype none
module bzh_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      vld_in,
  input  wire logic [bzh_pkg::CNT_W-1:0] idx,
  input  wire logic [bzh_pkg::CNT_W-1:0] count,
  output logic                           vld_out,
  output logic [bzh_pkg::T_W-1:0]        t_out
);
  import bzh_pkg::*;

  localparam int DVD_W = CNT_W + TQ;

  logic             v_r  [0:T_W];
  logic [CNT_W-1:0] r_r  [0:T_W];
  logic [CNT_W-1:0] n_r  [0:T_W];
  logic [T_W-1:0]   dq_r [0:T_W];

  logic [CNT_W-1:0] cnt_c, nseg_c, idx_c;
  logic [DVD_W-1:0] dvd_c;

  always_comb begin
    cnt_c  = (count < CNT_W'(2)) ? CNT_W'(2) : count;
    nseg_c = cnt_c - CNT_W'(1);
    idx_c  = (idx > nseg_c) ? nseg_c : idx;
    dvd_c  = {idx_c, {TQ{1'b0}}} + DVD_W'(nseg_c >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_in;
    end
    if (en) begin
      r_r[0]  <= CNT_W'(dvd_c[DVD_W-1:T_W]);
      dq_r[0] <= dvd_c[T_W-1:0];
      n_r[0]  <= nseg_c;
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= T_W; j++) begin : g_step
    logic [CNT_W:0]   rs;
    logic             ge;
    logic [CNT_W-1:0] r_nxt;
    logic [T_W-1:0]   dq_nxt;

    always_comb begin
      rs     = {r_r[j-1], dq_r[j-1][T_W-1]};
      ge     = rs >= {1'b0, n_r[j-1]};
      r_nxt  = ge ? CNT_W'(rs - {1'b0, n_r[j-1]}) : rs[CNT_W-1:0];
      dq_nxt = {dq_r[j-1][T_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
      if (en) begin
        r_r[j]  <= r_nxt;
        dq_r[j] <= dq_nxt;
        n_r[j]  <= n_r[j-1];
      end
    end
  end

  assign vld_out = v_r[T_W];
  assign t_out   = dq_r[T_W];

endmodule
`default_nettype wire

// ----- rtl/bzh_basis.sv -----
`default_nettype none
module bzh_basis (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    vld_in,
  input  wire logic [bzh_pkg::T_W-1:0] t_in,
  output logic                         vld_out,
  output bzh_pkg::weight_set_t         wts
);
  import bzh_pkg::*;

  logic           va_r, vb_r, vc_r, vd_r, ve_r;
  logic [T_W-1:0] a_t_r, a_u_r;
  logic [T_W-1:0] b_t_r, b_u_r, b_t2_r, b_u2_r;
  logic [T_W-1:0] c_t_r, c_u_r, c_t2_r, c_u2_r, c_t3_r, c_u3_r, c_tu22_r;
  logic [T_W-1:0] d_t_r, d_u_r, d_t4_r, d_u4_r, d_w2_r, d_w3_r, d_q1_r, d_q3_r, d_q2_r;
  weight_set_t    wts_r;

  logic [T_W+3:0] w1_c, w4_c;

  always_comb begin
    w1_c = (T_W+4)'(mulq(d_u4_r, d_t_r)) * (T_W+4)'(5);
    w4_c = (T_W+4)'(mulq(d_u_r, d_t4_r)) * (T_W+4)'(5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_in;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
    if (en) begin
      a_t_r    <= t_in;
      a_u_r    <= TONE - t_in;
      b_t_r    <= a_t_r;
      b_u_r    <= a_u_r;
      b_t2_r   <= mulq(a_t_r, a_t_r);
      b_u2_r   <= mulq(a_u_r, a_u_r);
      c_t_r    <= b_t_r;
      c_u_r    <= b_u_r;
      c_t2_r   <= b_t2_r;
      c_u2_r   <= b_u2_r;
      c_t3_r   <= mulq(b_t2_r, b_t_r);
      c_u3_r   <= mulq(b_u2_r, b_u_r);
      c_tu22_r <= mulq(b_u2_r, b_t2_r);
      d_t_r    <= c_t_r;
      d_u_r    <= c_u_r;
      d_t4_r   <= mulq(c_t3_r, c_t_r);
      d_u4_r   <= mulq(c_u3_r, c_u_r);
      d_w2_r   <= mulq(c_u3_r, c_t2_r);
      d_w3_r   <= mulq(c_u2_r, c_t3_r);
      d_q1_r   <= mulq(c_u3_r, c_t_r);
      d_q3_r   <= mulq(c_u_r, c_t3_r);
      d_q2_r   <= c_tu22_r;
      wts_r.w[0] <= mulq(d_u4_r, d_u_r);
      wts_r.w[1] <= w1_c[W_W-1:0];
      wts_r.w[2] <= W_W'({d_w2_r, 3'b000} + {d_w2_r, 1'b0});
      wts_r.w[3] <= W_W'({d_w3_r, 3'b000} + {d_w3_r, 1'b0});
      wts_r.w[4] <= w4_c[W_W-1:0];
      wts_r.w[5] <= mulq(d_t4_r, d_t_r);
      wts_r.q[0] <= d_u4_r;
      wts_r.q[1] <= W_W'({d_q1_r, 2'b00});
      wts_r.q[2] <= W_W'({d_q2_r, 2'b00} + {d_q2_r, 1'b0});
      wts_r.q[3] <= W_W'({d_q3_r, 2'b00});
      wts_r.q[4] <= d_t4_r;
    end
  end

  assign vld_out = ve_r;
  assign wts     = wts_r;

endmodule
`default_nettype wire

// ----- rtl/bzh_accum.sv -----
`default_nettype none
module bzh_accum (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           en,
  input  wire logic                                           vld_in,
  input  wire bzh_pkg::weight_set_t                           wts,
  input  wire logic [bzh_pkg::NPTS-1:0][bzh_pkg::CFG_W-1:0]   cp,
  output logic                                                vld_out,
  output logic signed [bzh_pkg::COORD_W-1:0]                  px_out,
  output logic signed [bzh_pkg::COORD_W-1:0]                  py_out,
  output logic signed [bzh_pkg::ACC_W-1:0]                    dx_out,
  output logic signed [bzh_pkg::ACC_W-1:0]                    dy_out
);
  import bzh_pkg::*;

  localparam int PW = 2 * COORD_W;
  localparam int DW = 2 * COORD_W + 1;
  localparam logic signed [ACC_W-1:0] HALF =
    signed'({{(ACC_W-TQ){1'b0}}, 1'b1, {(TQ-1){1'b0}}});

  logic vm_r, v1_r, v2_r, v3_r;
  logic signed [PW-1:0]    mx_r [NPTS];
  logic signed [PW-1:0]    my_r [NPTS];
  logic signed [DW-1:0]    qx_r [NPTS-1];
  logic signed [DW-1:0]    qy_r [NPTS-1];
  logic signed [ACC_W-1:0] sx_r [3];
  logic signed [ACC_W-1:0] sy_r [3];
  logic signed [ACC_W-1:0] tx_r [3];
  logic signed [ACC_W-1:0] ty_r [3];
  logic signed [ACC_W-1:0] ax_r, ay_r, dx_r, dy_r;
  logic signed [ACC_W-1:0] dx2_r, dy2_r;
  logic signed [COORD_W-1:0] px_r, py_r;

  logic signed [PW-1:0]      mx_nxt [NPTS];
  logic signed [PW-1:0]      my_nxt [NPTS];
  logic signed [DW-1:0]      qx_nxt [NPTS-1];
  logic signed [DW-1:0]      qy_nxt [NPTS-1];

  function automatic logic signed [COORD_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic fits;
    s    = (a + HALF) >>> TQ;
    fits = (&s[ACC_W-1:COORD_W-1]) | ~(|s[ACC_W-1:COORD_W-1]);
    if (fits) return s[COORD_W-1:0];
    return s[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      mx_nxt[k] = PW'(signed'({1'b0, wts.w[k]}) * signed'(cp[k][COORD_W-1:0]));
      my_nxt[k] = PW'(signed'({1'b0, wts.w[k]}) * signed'(cp[k][CFG_W-1:COORD_W]));
    end
    for (int k = 0; k < NPTS - 1; k++) begin
      qx_nxt[k] = DW'(signed'({1'b0, wts.q[k]}) *
        (COORD_W+1)'(signed'(cp[k+1][COORD_W-1:0]) - signed'(cp[k][COORD_W-1:0])));
      qy_nxt[k] = DW'(signed'({1'b0, wts.q[k]}) *
        (COORD_W+1)'(signed'(cp[k+1][CFG_W-1:COORD_W]) - signed'(cp[k][CFG_W-1:COORD_W])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      vm_r <= vld_in;
      v1_r <= vm_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      for (int k = 0; k < NPTS; k++) begin
        mx_r[k] <= mx_nxt[k];
        my_r[k] <= my_nxt[k];
      end
      for (int k = 0; k < NPTS - 1; k++) begin
        qx_r[k] <= qx_nxt[k];
        qy_r[k] <= qy_nxt[k];
      end
      for (int k = 0; k < 3; k++) begin
        sx_r[k] <= ACC_W'(mx_r[2*k]) + ACC_W'(mx_r[2*k+1]);
        sy_r[k] <= ACC_W'(my_r[2*k]) + ACC_W'(my_r[2*k+1]);
      end
      tx_r[0] <= ACC_W'(qx_r[0]) + ACC_W'(qx_r[1]);
      tx_r[1] <= ACC_W'(qx_r[2]) + ACC_W'(qx_r[3]);
      tx_r[2] <= ACC_W'(qx_r[4]);
      ty_r[0] <= ACC_W'(qy_r[0]) + ACC_W'(qy_r[1]);
      ty_r[1] <= ACC_W'(qy_r[2]) + ACC_W'(qy_r[3]);
      ty_r[2] <= ACC_W'(qy_r[4]);
      ax_r  <= sx_r[0] + sx_r[1] + sx_r[2];
      ay_r  <= sy_r[0] + sy_r[1] + sy_r[2];
      dx_r  <= tx_r[0] + tx_r[1] + tx_r[2];
      dy_r  <= ty_r[0] + ty_r[1] + ty_r[2];
      px_r  <= rnd_sat(ax_r);
      py_r  <= rnd_sat(ay_r);
      dx2_r <= dx_r;
      dy2_r <= dy_r;
    end
  end

  assign vld_out = v3_r;
  assign px_out  = px_r;
  assign py_out  = py_r;
  assign dx_out  = dx2_r;
  assign dy_out  = dy2_r;

endmodule
`default_nettype wire

// ----- rtl/bzh_cordic.sv -----
`default_nettype none
module bzh_cordic #(
  parameter int STEPS = bzh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                vld_in,
  input  wire logic signed [bzh_pkg::ACC_W-1:0]    dx,
  input  wire logic signed [bzh_pkg::ACC_W-1:0]    dy,
  input  wire logic [2*bzh_pkg::COORD_W-1:0]       side_in,
  output logic                                     vld_out,
  output logic [2*bzh_pkg::COORD_W-1:0]            side_out,
  output logic [bzh_pkg::HEAD_W-1:0]               heading
);
  import bzh_pkg::*;

  localparam int SW = 2 * COORD_W;

  typedef struct packed {
    logic             v;
    logic             zero;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [SW-1:0]    side;
  } norm_t;

  norm_t n1_r, n2_r, n3_r;
  norm_t n2_nxt, n3_nxt;

  logic                   n4_v_r, n4_zero_r;
  logic signed [CV_W-1:0] n4_n_r, n4_e_r;
  logic [SW-1:0]          n4_side_r;

  logic                   v_r    [0:STEPS];
  logic                   zero_r [0:STEPS];
  logic signed [CV_W-1:0] nv_r   [0:STEPS];
  logic signed [CV_W-1:0] ev_r   [0:STEPS];
  logic [ANG_W-1:0]       z_r    [0:STEPS];
  logic [SW-1:0]          side_r [0:STEPS];

  logic               ov_r;
  logic [SW-1:0]      oside_r;
  logic [HEAD_W-1:0]  head_r;

  function automatic norm_t shift2(input norm_t a, input int s1, input int s2);
    norm_t b;
    logic [MAG_W-1:0] m;
    b = a;
    m = b.ax | b.ay;
    if ((m >> (MAG_W - s1)) == '0) begin
      b.ax = b.ax << s1;
      b.ay = b.ay << s1;
    end
    m = b.ax | b.ay;
    if ((m >> (MAG_W - s2)) == '0) begin
      b.ax = b.ax << s2;
      b.ay = b.ay << s2;
    end
    return b;
  endfunction

  norm_t                  n4f;
  logic signed [CV_W-1:0] n4_n_nxt, n4_e_nxt;

  always_comb begin
    n2_nxt   = shift2(n1_r, 32, 16);
    n3_nxt   = shift2(n2_r, 8, 4);
    n4f      = shift2(n3_r, 2, 1);
    n4_e_nxt = signed'(CV_W'(n4f.ax >> (MAG_W - 40)));
    n4_n_nxt = signed'(CV_W'(n4f.ay >> (MAG_W - 40)));
    if (n3_r.sy) n4_n_nxt = -n4_n_nxt;
    if (n3_r.sx) n4_e_nxt = -n4_e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_r.v <= 1'b0;
      n2_r.v <= 1'b0;
      n3_r.v <= 1'b0;
      n4_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      n1_r.v <= vld_in;
      n2_r.v <= n2_nxt.v;
      n3_r.v <= n3_nxt.v;
      n4_v_r <= n3_r.v;
      v_r[0] <= n4_v_r;
    end
    if (en) begin
      n1_r.zero <= (dx == '0) && (dy == '0);
      n1_r.sx   <= dx[ACC_W-1];
      n1_r.sy   <= dy[ACC_W-1];
      n1_r.ax   <= MAG_W'(dx[ACC_W-1] ? -dx : dx);
      n1_r.ay   <= MAG_W'(dy[ACC_W-1] ? -dy : dy);
      n1_r.side <= side_in;
      {n2_r.zero, n2_r.sx, n2_r.sy, n2_r.ax, n2_r.ay, n2_r.side} <=
        {n2_nxt.zero, n2_nxt.sx, n2_nxt.sy, n2_nxt.ax, n2_nxt.ay, n2_nxt.side};
      {n3_r.zero, n3_r.sx, n3_r.sy, n3_r.ax, n3_r.ay, n3_r.side} <=
        {n3_nxt.zero, n3_nxt.sx, n3_nxt.sy, n3_nxt.ax, n3_nxt.ay, n3_nxt.side};
      n4_zero_r <= n3_r.zero;
      n4_n_r    <= n4_n_nxt;
      n4_e_r    <= n4_e_nxt;
      n4_side_r <= n3_r.side;
      // southern half: rotate by a half turn first
      if (n4_n_r < 0) begin
        nv_r[0] <= -n4_n_r;
        ev_r[0] <= -n4_e_r;
        z_r[0]  <= {1'b1, {(ANG_W-1){1'b0}}};
      end else begin
        nv_r[0] <= n4_n_r;
        ev_r[0] <= n4_e_r;
        z_r[0]  <= '0;
      end
      zero_r[0] <= n4_zero_r;
      side_r[0] <= n4_side_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [CV_W-1:0] n_nxt, e_nxt;
    logic [ANG_W-1:0]       z_nxt;

    always_comb begin
      if (ev_r[i] > 0) begin
        n_nxt = nv_r[i] + (ev_r[i] >>> i);
        e_nxt = ev_r[i] - (nv_r[i] >>> i);
        z_nxt = z_r[i] + atan_entry(5'(i));
      end else begin
        n_nxt = nv_r[i] - (ev_r[i] >>> i);
        e_nxt = ev_r[i] + (nv_r[i] >>> i);
        z_nxt = z_r[i] - atan_entry(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        nv_r[i+1]   <= n_nxt;
        ev_r[i+1]   <= e_nxt;
        z_r[i+1]    <= z_nxt;
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  logic [ANG_W-1:0] zr_c;
  assign zr_c = z_r[STEPS] + ANG_W'(32'h8000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_r[STEPS];
    end
    if (en) begin
      oside_r <= side_r[STEPS];
      head_r  <= zero_r[STEPS] ? '0 : zr_c[ANG_W-1 -: HEAD_W];
    end
  end

  assign vld_out  = ov_r;
  assign side_out = oside_r;
  assign heading  = head_r;

endmodule
`default_nettype wire
